// ===== rtl/core/mvt_pkg.sv =====
// shared types and constants for the 4x4 matrix by vector transform
`timescale 1ns / 1ps

package mvt_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIM        = 4;
  localparam int COEF_N     = DIM * DIM;
  localparam int IDX_W      = $clog2(COEF_N);
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int SUM_W      = PROD_W + $clog2(DIM);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_XFORM = 1'b1
  } req_type_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    data_t            data;
  } coef_wr_t;

  localparam data_t COEF_ONE   = data_t'(1 << FRAC_BITS);
  localparam data_t DATA_MAX   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DATA_MIN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam sum_t  ROUND_HALF = sum_t'(1 << (FRAC_BITS - 1));

endpackage

// ===== rtl/core/mvt_coef_store.sv =====
// coefficient register file, column-major, reset to the identity matrix
`timescale 1ns / 1ps

module mvt_coef_store (
  input  logic             clk,
  input  logic             rst_n,
  input  mvt_pkg::coef_wr_t wr,
  output mvt_pkg::data_t   coef [mvt_pkg::COEF_N]
);

  mvt_pkg::data_t coef_r [mvt_pkg::COEF_N];

  // diagonal slots: column equals row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < mvt_pkg::COEF_N; k++) begin
        coef_r[k] <= ((k >> $clog2(mvt_pkg::DIM)) == (k & (mvt_pkg::DIM - 1))) ?
                     mvt_pkg::COEF_ONE : '0;
      end
    end else if (wr.we) begin
      coef_r[wr.idx] <= wr.data;
    end
  end

  assign coef = coef_r;

endmodule

// ===== rtl/core/mvt_mul_stage.sv =====
// product register: all sixteen coefficient by element products
`timescale 1ns / 1ps

module mvt_mul_stage (
  input  logic           clk,
  input  logic           en,
  input  mvt_pkg::data_t vec    [mvt_pkg::DIM],
  input  mvt_pkg::data_t coef   [mvt_pkg::COEF_N],
  output mvt_pkg::prod_t prod_r [mvt_pkg::DIM][mvt_pkg::DIM]
);

  mvt_pkg::prod_t prod_nxt [mvt_pkg::DIM][mvt_pkg::DIM];

  // row i, column j: vec[j] * coef[i + 4j]
  always_comb begin
    for (int i = 0; i < mvt_pkg::DIM; i++) begin
      for (int j = 0; j < mvt_pkg::DIM; j++) begin
        prod_nxt[i][j] = vec[j] * coef[i + mvt_pkg::DIM * j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== rtl/core/mvt_round_sat.sv =====
// one output lane: sum of products, round to nearest, saturate
`timescale 1ns / 1ps

module mvt_round_sat (
  input  mvt_pkg::prod_t prod [mvt_pkg::DIM],
  output mvt_pkg::data_t res,
  output logic           sat
);

  mvt_pkg::sum_t sum;
  mvt_pkg::sum_t rnd;
  mvt_pkg::sum_t shf;
  logic [mvt_pkg::SUM_W-mvt_pkg::DATA_WIDTH:0] hi;

  always_comb begin
    sum = '0;
    for (int j = 0; j < mvt_pkg::DIM; j++) begin
      sum = sum + mvt_pkg::sum_t'(prod[j]);
    end
    rnd = sum + mvt_pkg::ROUND_HALF;
    shf = rnd >>> mvt_pkg::FRAC_BITS;
    hi  = shf[mvt_pkg::SUM_W-1:mvt_pkg::DATA_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      res = shf[mvt_pkg::DATA_WIDTH-1:0];
      sat = 1'b0;
    end else begin
      res = shf[mvt_pkg::SUM_W-1] ? mvt_pkg::DATA_MIN : mvt_pkg::DATA_MAX;
      sat = 1'b1;
    end
  end

endmodule

// ===== rtl/core/matrix4_vector_transform.sv =====
// top level of the 4x4 matrix by vector transform engine
`timescale 1ns / 1ps

// Takes one transaction per cycle while in_stall is low. A load transaction writes one coefficient of the
// column-major store (slot column*4+row) as it leaves the input register and gives no
// result; the store comes out of reset as the identity matrix. A transform transaction
// passes in turn through the input register, then the product register fed by
// sixteen 32x32 signed multipliers, then the result register fed by the four-way sum,
// round-to-nearest (ties up) and saturation. Transactions stay in order, so a
// transform sees exactly the loads accepted before it. A result-side stall reaches the
// input only if product and result registers are full and the input holds a transform.

module matrix4_vector_transform (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_req_type,
  input  logic [mvt_pkg::IDX_W-1:0] in_coef_index,
  input  mvt_pkg::data_t            in_coef_value,
  input  mvt_pkg::data_t            in_vec_x,
  input  mvt_pkg::data_t            in_vec_y,
  input  mvt_pkg::data_t            in_vec_z,
  input  mvt_pkg::data_t            in_vec_w,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mvt_pkg::data_t            out_x,
  output mvt_pkg::data_t            out_y,
  output mvt_pkg::data_t            out_z,
  output mvt_pkg::data_t            out_w,
  output logic                      out_saturated
);

  // input register
  logic                      in_v_r;
  logic                      in_v_nxt;
  mvt_pkg::req_type_t        req_r;
  logic [mvt_pkg::IDX_W-1:0] idx_r;
  mvt_pkg::data_t            val_r;
  mvt_pkg::data_t            vec_r [mvt_pkg::DIM];

  // product and result stages
  logic                      mul_v_r;
  logic                      mul_v_nxt;
  logic                      out_v_r;
  logic                      out_v_nxt;
  mvt_pkg::data_t            out_data_r [mvt_pkg::DIM];
  logic                      out_sat_r;

  logic                      out_free;
  logic                      mul_free;
  logic                      in_leave;
  logic                      in_free;
  logic                      mul_en;
  logic                      in_acc;

  mvt_pkg::coef_wr_t         coef_wr;
  mvt_pkg::data_t            coef [mvt_pkg::COEF_N];
  mvt_pkg::prod_t            prod_r [mvt_pkg::DIM][mvt_pkg::DIM];
  mvt_pkg::data_t            res [mvt_pkg::DIM];
  logic [mvt_pkg::DIM-1:0]   sat;

  // pipeline flow
  assign out_free = !out_v_r || !out_stall;
  assign mul_free = !mul_v_r || out_free;
  assign in_leave = in_v_r && ((req_r == mvt_pkg::REQ_LOAD) || mul_free);
  assign in_free  = !in_v_r || in_leave;
  assign in_stall = !in_free;
  assign in_acc   = in_valid && in_free;
  assign mul_en   = in_v_r && (req_r == mvt_pkg::REQ_XFORM) && mul_free;

  assign in_v_nxt  = in_free  ? in_valid : in_v_r;
  assign mul_v_nxt = mul_free ? mul_en   : mul_v_r;
  assign out_v_nxt = out_free ? mul_v_r  : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      mul_v_r <= mul_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r    <= mvt_pkg::req_type_t'(in_req_type);
      idx_r    <= in_coef_index;
      val_r    <= in_coef_value;
      vec_r[0] <= in_vec_x;
      vec_r[1] <= in_vec_y;
      vec_r[2] <= in_vec_z;
      vec_r[3] <= in_vec_w;
    end
  end

  // loads update the store as they leave the input register
  assign coef_wr.we   = in_v_r && (req_r == mvt_pkg::REQ_LOAD);
  assign coef_wr.idx  = idx_r;
  assign coef_wr.data = val_r;

  mvt_coef_store u_coef_store (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (coef_wr),
    .coef  (coef)
  );

  mvt_mul_stage u_mul_stage (
    .clk    (clk),
    .en     (mul_en),
    .vec    (vec_r),
    .coef   (coef),
    .prod_r (prod_r)
  );

  for (genvar i = 0; i < mvt_pkg::DIM; i++) begin : g_lane
    mvt_round_sat u_round_sat (
      .prod (prod_r[i]),
      .res  (res[i]),
      .sat  (sat[i])
    );
  end

  always_ff @(posedge clk) begin
    if (out_free && mul_v_r) begin
      out_data_r <= res;
      out_sat_r  <= |sat;
    end
  end

  assign out_valid     = out_v_r;
  assign out_x         = out_data_r[0];
  assign out_y         = out_data_r[1];
  assign out_z         = out_data_r[2];
  assign out_w         = out_data_r[3];
  assign out_saturated = out_sat_r;

`ifndef SYNTHESIS
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_result_from_product: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_v_r || !out_stall) && !mul_v_r |=> !out_v_r)
    else $error("result transaction without a product behind it");

  a_product_from_xform: assert property (@(posedge clk) disable iff (!rst_n)
    !mul_v_r && !(in_v_r && req_r == mvt_pkg::REQ_XFORM) |=> !mul_v_r)
    else $error("product stage filled without a transform");

  a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_sat_r |->
      (out_x == mvt_pkg::DATA_MAX || out_x == mvt_pkg::DATA_MIN ||
       out_y == mvt_pkg::DATA_MAX || out_y == mvt_pkg::DATA_MIN ||
       out_z == mvt_pkg::DATA_MAX || out_z == mvt_pkg::DATA_MIN ||
       out_w == mvt_pkg::DATA_MAX || out_w == mvt_pkg::DATA_MIN))
    else $error("saturated flag without a clipped element");
`endif

endmodule

// ===== tb/sv/matrix4_vector_transform_tb.sv =====
// self-checking testbench for the 4x4 matrix by vector transform engine
`timescale 1ns / 1ps

module matrix4_vector_transform_tb;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 950;

  typedef struct packed {
    mvt_pkg::data_t x;
    mvt_pkg::data_t y;
    mvt_pkg::data_t z;
    mvt_pkg::data_t w;
    logic           sat;
  } vertex_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic           in_req_type = 1'b0;
  logic [3:0]     in_coef_index = '0;
  mvt_pkg::data_t in_coef_value = '0;
  mvt_pkg::data_t in_vec_x = '0;
  mvt_pkg::data_t in_vec_y = '0;
  mvt_pkg::data_t in_vec_z = '0;
  mvt_pkg::data_t in_vec_w = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  mvt_pkg::data_t out_x;
  mvt_pkg::data_t out_y;
  mvt_pkg::data_t out_z;
  mvt_pkg::data_t out_w;
  logic           out_saturated;

  vertex_t        pending_vertices[$];
  mvt_pkg::data_t coef_shadow[mvt_pkg::COEF_N];
  bit      send_idle = 1'b1;
  bit      recv_idle = 1'b1;
  int      stall_left = 0;
  int      quiet_cycles = 0;
  int      error_count = 0;
  int      n_loads = 0;
  int      n_xforms = 0;
  int      n_results = 0;
  int      n_sat = 0;

  always #1 clk = ~clk;

  matrix4_vector_transform uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_vec_z      (in_vec_z),
    .in_vec_w      (in_vec_w),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w         (out_w),
    .out_saturated (out_saturated)
  );

  // full-precision dot products, round half up, clip to the data range
  function automatic vertex_t transform_vertex(input mvt_pkg::data_t vx,
                                               input mvt_pkg::data_t vy,
                                               input mvt_pkg::data_t vz,
                                               input mvt_pkg::data_t vw);
    mvt_pkg::data_t     vec[4];
    mvt_pkg::data_t     elem[4];
    logic signed [71:0] acc;
    logic signed [63:0] prod;
    vertex_t            res;
    int                 i;
    int                 j;
    vec[0] = vx;
    vec[1] = vy;
    vec[2] = vz;
    vec[3] = vw;
    res.sat = 1'b0;
    for (i = 0; i < mvt_pkg::DIM; i++) begin
      acc = '0;
      for (j = 0; j < mvt_pkg::DIM; j++) begin
        prod = vec[j] * coef_shadow[i + mvt_pkg::DIM * j];
        acc = acc + prod;
      end
      acc = (acc + (72'sd1 <<< (mvt_pkg::FRAC_BITS - 1))) >>> mvt_pkg::FRAC_BITS;
      if (acc > mvt_pkg::DATA_MAX) begin
        elem[i] = mvt_pkg::DATA_MAX;
        res.sat = 1'b1;
      end else if (acc < mvt_pkg::DATA_MIN) begin
        elem[i] = mvt_pkg::DATA_MIN;
        res.sat = 1'b1;
      end else begin
        elem[i] = mvt_pkg::data_t'(acc);
      end
    end
    res.x = elem[0];
    res.y = elem[1];
    res.z = elem[2];
    res.w = elem[3];
    return res;
  endfunction

  function automatic mvt_pkg::data_t draw_data();
    case ($urandom_range(0, 9))
      0: return mvt_pkg::DATA_MAX;
      1: return mvt_pkg::DATA_MIN;
      2, 3, 4, 5: return mvt_pkg::data_t'(int'($urandom_range(0, 8 << mvt_pkg::FRAC_BITS))
                                          - (4 << mvt_pkg::FRAC_BITS));
      6: return mvt_pkg::data_t'(int'($urandom_range(0, 64)) - 32);
      7: return $urandom_range(0, 1) ? mvt_pkg::COEF_ONE : -mvt_pkg::COEF_ONE;
      default: return mvt_pkg::data_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, field, got, want);
    error_count++;
  endtask

  task automatic send_item(input mvt_pkg::req_type_t kind, input logic [3:0] idx,
                           input mvt_pkg::data_t value,
                           input mvt_pkg::data_t vx, input mvt_pkg::data_t vy,
                           input mvt_pkg::data_t vz, input mvt_pkg::data_t vw);
    int gap;
    gap = send_idle ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_req_type   = kind;
    in_coef_index = idx;
    in_coef_value = value;
    in_vec_x      = vx;
    in_vec_y      = vy;
    in_vec_z      = vz;
    in_vec_w      = vw;
    do @(posedge clk); while (in_stall);
    if (kind == mvt_pkg::REQ_LOAD) begin
      coef_shadow[idx] = value;
      n_loads++;
    end else begin
      pending_vertices.push_back(transform_vertex(vx, vy, vz, vw));
      n_xforms++;
    end
  endtask

  // unused fields carry random junk
  task automatic send_load(input logic [3:0] idx, input mvt_pkg::data_t value);
    send_item(mvt_pkg::REQ_LOAD, idx, value, mvt_pkg::data_t'($urandom),
              mvt_pkg::data_t'($urandom), mvt_pkg::data_t'($urandom),
              mvt_pkg::data_t'($urandom));
  endtask

  task automatic send_xform(input mvt_pkg::data_t vx, input mvt_pkg::data_t vy,
                            input mvt_pkg::data_t vz, input mvt_pkg::data_t vw);
    send_item(mvt_pkg::REQ_XFORM, 4'($urandom_range(0, 15)), mvt_pkg::data_t'($urandom),
              vx, vy, vz, vw);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_identity();
    send_xform(mvt_pkg::COEF_ONE, -32'sh0002_8000, mvt_pkg::DATA_MAX, mvt_pkg::DATA_MIN);
    send_xform('0, 32'sd1, -32'sd1, 32'sh7FFF_0000);
  endtask

  // off-diagonal slots check the column-major layout
  task automatic test_column_order();
    send_load(4'd1, 32'sh0002_0000);
    send_load(4'd4, -32'sh0003_0000);
    send_xform(mvt_pkg::COEF_ONE, mvt_pkg::COEF_ONE, '0, '0);
  endtask

  // smallest coefficient, vector on and around the half step
  task automatic test_rounding_ties();
    send_load(4'd10, 32'sd1);
    send_xform('0, '0, 32'sd32768, '0);
    send_xform('0, '0, -32'sd32768, '0);
    send_xform('0, '0, -32'sd32769, '0);
    send_xform('0, '0, 32'sd32767, '0);
  endtask

  task automatic test_saturation();
    send_load(4'd0, mvt_pkg::DATA_MIN);
    send_load(4'd4, mvt_pkg::DATA_MIN);
    send_load(4'd8, mvt_pkg::DATA_MIN);
    send_load(4'd12, mvt_pkg::DATA_MIN);
    send_load(4'd15, mvt_pkg::DATA_MAX);
    send_xform(mvt_pkg::DATA_MIN, mvt_pkg::DATA_MIN, mvt_pkg::DATA_MIN, mvt_pkg::DATA_MIN);
    send_xform(mvt_pkg::DATA_MAX, mvt_pkg::DATA_MAX, mvt_pkg::DATA_MAX, mvt_pkg::DATA_MAX);
    send_xform('0, '0, '0, '0);
  endtask

  // random mix of vertices, single loads and full matrix reloads, idling pattern changes per block
  task automatic test_random_stream();
    int sent;
    int block_end;
    int mode;
    int pick;
    int k;
    bit drained;
    sent = 0;
    block_end = 0;
    mode = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= block_end) begin
        send_idle = mode[0];
        recv_idle = mode[1];
        mode++;
        block_end = sent + $urandom_range(30, 90);
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        wait_for_drain();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_xform(draw_data(), draw_data(), draw_data(), draw_data());
        sent++;
      end else if (pick < 88) begin
        send_load(4'($urandom_range(0, 15)), draw_data());
        sent++;
      end else begin
        for (k = 0; k < mvt_pkg::COEF_N; k++) send_load(4'(k), draw_data());
        sent += mvt_pkg::COEF_N;
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_saturated) n_sat++;
      stall_left = recv_idle ? $urandom_range(0, 14) : 0;
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected transaction", out_x, '0);
      end else begin
        want = pending_vertices.pop_front();
        if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
        if (out_w !== want.w) report_mismatch("out_w", out_w, want.w);
        if (out_saturated !== want.sat)
          report_mismatch("out_saturated", 32'(out_saturated), 32'(want.sat));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_vertices.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < mvt_pkg::COEF_N; i++)
      coef_shadow[i] = (i % 5 == 0) ? mvt_pkg::COEF_ONE : '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_identity();
    test_column_order();
    test_rounding_ties();
    test_saturation();
    test_random_stream();
    wait_for_drain();
    recv_idle = 1'b0;
    repeat (20) @(posedge clk);
    $display("covered %0d coefficient loads and %0d transforms; %0d results checked, %0d clipped",
             n_loads, n_xforms, n_results, n_sat);
    $display("both sides idled and stalled in varied blocks, with one full drain mid-stream");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
